[rtl/lppc_pkg.sv]
`default_nettype none

package lppc_pkg;

    // Controller modes
    typedef enum logic [1:0] {
        MODE_RUN,
        MODE_ARMED,
        MODE_CANCELED,
        MODE_OFF
    } mode_t;

    // Configuration register indexes
    localparam int unsigned CFG_INDEX_W = 3;
    localparam logic [CFG_INDEX_W-1:0] CFG_HOLD_TICKS   = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_CANCEL_TICKS = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_OFF_TICKS    = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] CFG_BLINK_TICKS  = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] CFG_DIM_PERIOD   = 3'd4;
    localparam logic [CFG_INDEX_W-1:0] CFG_VOLTS        = 3'd5;

    localparam int unsigned CFG_DATA_W = 16;

    // Register reset values
    localparam logic [15:0] HOLD_TICKS_RST   = 16'd48;
    localparam logic [7:0]  CANCEL_TICKS_RST = 8'd240;
    localparam logic [7:0]  OFF_TICKS_RST    = 8'd120;
    localparam logic [7:0]  BLINK_TICKS_RST  = 8'd6;
    localparam logic [4:0]  DIM_PERIOD_RST   = 5'd8;
    localparam logic [4:0]  VOLTS_RST        = 5'd5;

    // Voltage codes
    localparam logic [2:0] VSEL_5V  = 3'd0;
    localparam logic [2:0] VSEL_9V  = 3'd1;
    localparam logic [2:0] VSEL_12V = 3'd2;
    localparam logic [2:0] VSEL_15V = 3'd3;
    localparam logic [2:0] VSEL_20V = 3'd4;

    typedef struct packed {
        logic [15:0] hold_ticks;
        logic [7:0]  cancel_ticks;
        logic [7:0]  off_ticks;
        logic [7:0]  blink_ticks;
        logic [4:0]  dim_period;
        logic [4:0]  volts;
    } cfg_t;

    typedef struct packed {
        logic       power_enable;
        logic       led_lit;
        logic [2:0] voltage_select;
        logic       timer_restart;
    } res_t;

    // Map the volts setting to a supply code; anything unknown selects 5V
    function automatic logic [2:0] volt_code(input logic [4:0] v);
        logic [2:0] code;
        begin
            case (v)
                5'd9:    code = VSEL_9V;
                5'd12:   code = VSEL_12V;
                5'd15:   code = VSEL_15V;
                5'd20:   code = VSEL_20V;
                default: code = VSEL_5V;
            endcase
            return code;
        end
    endfunction

endpackage

`default_nettype wire

[rtl/lppc_cfg.sv]
`default_nettype none

module lppc_cfg (
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    input  wire logic                               wr_en,
    input  wire logic [lppc_pkg::CFG_INDEX_W-1:0]   wr_index,
    input  wire logic [lppc_pkg::CFG_DATA_W-1:0]    wr_data,
    output lppc_pkg::cfg_t                          cfg
);

    lppc_pkg::cfg_t cfg_reg;
    lppc_pkg::cfg_t cfg_next;

    // Decode the register index and merge the write data
    always_comb
    begin
        cfg_next = cfg_reg;
        if (wr_en)
        begin
            unique case (wr_index)
                lppc_pkg::CFG_HOLD_TICKS:   cfg_next.hold_ticks   = wr_data;
                lppc_pkg::CFG_CANCEL_TICKS: cfg_next.cancel_ticks = wr_data[7:0];
                lppc_pkg::CFG_OFF_TICKS:    cfg_next.off_ticks    = wr_data[7:0];
                lppc_pkg::CFG_BLINK_TICKS:  cfg_next.blink_ticks  = wr_data[7:0];
                lppc_pkg::CFG_DIM_PERIOD:   cfg_next.dim_period   = wr_data[4:0];
                lppc_pkg::CFG_VOLTS:        cfg_next.volts        = wr_data[4:0];
                default:                    cfg_next = cfg_reg;
            endcase
        end
    end

    // Hold the register file
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.hold_ticks   <= lppc_pkg::HOLD_TICKS_RST;
            cfg_reg.cancel_ticks <= lppc_pkg::CANCEL_TICKS_RST;
            cfg_reg.off_ticks    <= lppc_pkg::OFF_TICKS_RST;
            cfg_reg.blink_ticks  <= lppc_pkg::BLINK_TICKS_RST;
            cfg_reg.dim_period   <= lppc_pkg::DIM_PERIOD_RST;
            cfg_reg.volts        <= lppc_pkg::VOLTS_RST;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

`default_nettype wire

[rtl/lppc_core.sv]
`default_nettype none

module lppc_core (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            step,
    input  wire logic            held,
    input  wire logic            tick,
    input  wire lppc_pkg::cfg_t  cfg,
    output lppc_pkg::res_t       res
);

    lppc_pkg::mode_t mode_reg, mode_next;
    logic [15:0] hold_count_reg, hold_count_next;
    logic [7:0]  cancel_count_reg, cancel_count_next;
    logic [7:0]  off_count_reg, off_count_next;
    logic [7:0]  blink_count_reg, blink_count_next;
    logic [3:0]  dim_count_reg, dim_count_next;
    logic        led_reg, led_next;
    logic        power_reg, power_next;

    logic [15:0] hold_inc;
    logic [7:0]  cancel_inc;
    logic [7:0]  off_inc;
    logic [7:0]  blink_inc;
    logic [4:0]  dim_inc;
    logic        canceled;
    logic        off_adv;
    logic        blink_wrap;
    logic        dim_wrap;
    logic        restart;

    // Counter increments, wrapping at their widths
    assign hold_inc   = hold_count_reg + 16'd1;
    assign cancel_inc = cancel_count_reg + 8'd1;
    assign off_inc    = off_count_reg + 8'd1;
    assign blink_inc  = blink_count_reg + 8'd1;
    assign dim_inc    = {1'b0, dim_count_reg} + 5'd1;

    assign canceled   = tick && (cancel_inc == cfg.cancel_ticks);
    assign off_adv    = tick && (off_count_reg < cfg.off_ticks);
    assign blink_wrap = blink_inc >= cfg.blink_ticks;
    assign dim_wrap   = (dim_inc >= cfg.dim_period) || dim_inc[4];

    // Next state for one poll
    always_comb
    begin
        mode_next         = mode_reg;
        hold_count_next   = hold_count_reg;
        cancel_count_next = cancel_count_reg;
        off_count_next    = off_count_reg;
        blink_count_next  = blink_count_reg;
        dim_count_next    = dim_count_reg;
        led_next          = led_reg;
        power_next        = power_reg;

        unique case (mode_reg)
            lppc_pkg::MODE_RUN:
            begin
                if (held)
                begin
                    if (tick)
                    begin
                        hold_count_next = hold_inc;
                        if (hold_inc == cfg.hold_ticks)
                        begin
                            mode_next         = lppc_pkg::MODE_ARMED;
                            cancel_count_next = 8'd0;
                            dim_count_next    = 4'd0;
                        end
                    end
                end
                else
                begin
                    hold_count_next = 16'd0;
                    led_next        = 1'b1;
                end
            end
            lppc_pkg::MODE_ARMED:
            begin
                if (held)
                begin
                    if (tick)
                        cancel_count_next = cancel_inc;
                    if (canceled)
                    begin
                        led_next  = 1'b1;
                        mode_next = lppc_pkg::MODE_CANCELED;
                    end
                    else
                    begin
                        // Light only the first poll of each dimming period
                        led_next       = (dim_count_reg == 4'd0);
                        dim_count_next = dim_wrap ? 4'd0 : dim_inc[3:0];
                    end
                end
                else
                begin
                    power_next       = 1'b0;
                    off_count_next   = 8'd0;
                    blink_count_next = 8'd0;
                    mode_next        = lppc_pkg::MODE_OFF;
                end
            end
            lppc_pkg::MODE_CANCELED:
            begin
                if (!held)
                begin
                    hold_count_next = 16'd0;
                    led_next        = 1'b1;
                    mode_next       = lppc_pkg::MODE_RUN;
                end
            end
            lppc_pkg::MODE_OFF:
            begin
                if (off_adv)
                begin
                    off_count_next = off_inc;
                    if (blink_wrap)
                    begin
                        led_next         = !led_reg;
                        blink_count_next = 8'd0;
                    end
                    else
                    begin
                        blink_count_next = blink_inc;
                    end
                end
                // Restore power once the off time is used up
                if (off_count_next >= cfg.off_ticks)
                begin
                    power_next      = 1'b1;
                    led_next        = 1'b1;
                    hold_count_next = 16'd0;
                    mode_next       = lppc_pkg::MODE_RUN;
                end
            end
            default:
            begin
                mode_next = mode_reg;
            end
        endcase
    end

    // Ask for a timer restart on every release outside the off period
    always_comb
    begin
        unique case (mode_reg) inside
            lppc_pkg::MODE_RUN,
            lppc_pkg::MODE_ARMED,
            lppc_pkg::MODE_CANCELED: restart = !held;
            lppc_pkg::MODE_OFF:      restart = 1'b0;
            default:                 restart = 1'b0;
        endcase
    end

    assign res.power_enable   = power_next;
    assign res.led_lit        = led_next;
    assign res.voltage_select = lppc_pkg::volt_code(cfg.volts);
    assign res.timer_restart  = restart;

    // Advance the state on each processed poll
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg         <= lppc_pkg::MODE_RUN;
            hold_count_reg   <= 16'd0;
            cancel_count_reg <= 8'd0;
            off_count_reg    <= 8'd0;
            blink_count_reg  <= 8'd0;
            dim_count_reg    <= 4'd0;
            led_reg          <= 1'b1;
            power_reg        <= 1'b1;
        end
        else if (step)
        begin
            mode_reg         <= mode_next;
            hold_count_reg   <= hold_count_next;
            cancel_count_reg <= cancel_count_next;
            off_count_reg    <= off_count_next;
            blink_count_reg  <= blink_count_next;
            dim_count_reg    <= dim_count_next;
            led_reg          <= led_next;
            power_reg        <= power_next;
        end
    end

endmodule

`default_nettype wire

[rtl/long_press_power_cycle_controller_top.sv]
`default_nettype none

// Long-press power-cycle controller. Each input transaction is one poll of the
// button level and the timer tick flag, and yields exactly one result
// transaction carrying the power enable, LED level, voltage code and timer
// restart request. The block takes one poll per clock cycle while the result
// channel does not stall; a poll passes an input register and then the state
// update into the result register, which holds its result until the consumer
// takes it. The rate is set by the single state update stage, which handles a
// poll every cycle unless the result stalls; a stalled result holds the polled
// input, and the input channel stalls in the same cycle. Configuration writes
// are always ready, take effect on the next poll, and should be made while no
// poll is in flight; writes to unknown indexes are dropped.
module long_press_power_cycle_controller_top (
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    // input channel
    input  wire logic                               in_valid,
    output logic                                    in_stall,
    input  wire logic                               button_held,
    input  wire logic                               tick,
    // result channel
    output logic                                    out_valid,
    input  wire logic                               out_stall,
    output logic                                    power_enable,
    output logic                                    led_lit,
    output logic [2:0]                              voltage_select,
    output logic                                    timer_restart,
    // configuration channel
    input  wire logic                               cfg_valid,
    output logic                                    cfg_ready,
    input  wire logic [lppc_pkg::CFG_INDEX_W-1:0]   cfg_index,
    input  wire logic [lppc_pkg::CFG_DATA_W-1:0]    cfg_data
);

    lppc_pkg::cfg_t cfg;
    lppc_pkg::res_t res;
    lppc_pkg::res_t res_reg;

    logic in_valid_reg;
    logic held_reg;
    logic tick_reg;
    logic out_valid_reg;
    logic out_load;
    logic step;

    assign cfg_ready = 1'b1;

    lppc_cfg u_cfg (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_en    (cfg_valid && cfg_ready),
        .wr_index (cfg_index),
        .wr_data  (cfg_data),
        .cfg      (cfg)
    );

    // The result register can take a new result when empty or draining
    assign out_load = !out_valid_reg || !out_stall;
    assign step     = in_valid_reg && out_load;
    assign in_stall = in_valid_reg && !out_load;

    // Capture the poll
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_valid_reg <= 1'b0;
        else if (!in_stall)
            in_valid_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && !in_stall)
        begin
            held_reg <= button_held;
            tick_reg <= tick;
        end
    end

    lppc_core u_core (
        .clk   (clk),
        .rst_n (rst_n),
        .step  (step),
        .held  (held_reg),
        .tick  (tick_reg),
        .cfg   (cfg),
        .res   (res)
    );

    // Hold the result until the consumer takes it
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (out_load)
            out_valid_reg <= step;
    end

    always_ff @(posedge clk)
    begin
        if (step)
            res_reg <= res;
    end

    assign out_valid      = out_valid_reg;
    assign power_enable   = res_reg.power_enable;
    assign led_lit        = res_reg.led_lit;
    assign voltage_select = res_reg.voltage_select;
    assign timer_restart  = res_reg.timer_restart;

    // A poll blocked by a full result register stays put
    assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |=> in_valid_reg && $stable(held_reg) && $stable(tick_reg))
        else $error("blocked poll was lost or changed");

    // Every processed poll shows up as a result
    assert property (@(posedge clk) disable iff (!rst_n)
        step |=> out_valid)
        else $error("processed poll produced no result");

    // A taken result with nothing behind it empties the output
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_stall && !step |=> !out_valid)
        else $error("result delivered twice");

    // Only defined voltage codes leave the block
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (voltage_select == lppc_pkg::VSEL_5V
                       || voltage_select == lppc_pkg::VSEL_9V
                       || voltage_select == lppc_pkg::VSEL_12V
                       || voltage_select == lppc_pkg::VSEL_15V
                       || voltage_select == lppc_pkg::VSEL_20V))
        else $error("undefined voltage code");

endmodule

`default_nettype wire

[sim/long_press_power_cycle_controller_top_tb.sv]
`default_nettype none

module long_press_power_cycle_controller_top_tb;

    // Indexes that map to no register; writes there must be dropped
    localparam logic [lppc_pkg::CFG_INDEX_W-1:0] SPARE_INDEX_A = 3'd6;
    localparam logic [lppc_pkg::CFG_INDEX_W-1:0] SPARE_INDEX_B = 3'd7;

    // Tracks the controller state per poll and checks the outputs in order
    class power_cycle_scoreboard;
        logic [15:0] hold_lim;
        logic [7:0]  cancel_lim;
        logic [7:0]  off_lim;
        logic [7:0]  blink_lim;
        logic [4:0]  dim_per;
        logic [4:0]  volts_set;

        lppc_pkg::mode_t mode;
        logic [15:0] hold_cnt;
        logic [7:0]  cancel_cnt;
        logic [7:0]  off_cnt;
        logic [7:0]  blink_cnt;
        logic [3:0]  dim_cnt;
        logic        led;
        logic        pwr;

        lppc_pkg::res_t pending_outputs[$];
        int          errors;
        int          checked;
        int          arms;
        int          cancels;
        int          power_cycles;

        function new();
            hold_lim   = lppc_pkg::HOLD_TICKS_RST;
            cancel_lim = lppc_pkg::CANCEL_TICKS_RST;
            off_lim    = lppc_pkg::OFF_TICKS_RST;
            blink_lim  = lppc_pkg::BLINK_TICKS_RST;
            dim_per    = lppc_pkg::DIM_PERIOD_RST;
            volts_set  = lppc_pkg::VOLTS_RST;
            mode       = lppc_pkg::MODE_RUN;
            hold_cnt   = '0;
            cancel_cnt = '0;
            off_cnt    = '0;
            blink_cnt  = '0;
            dim_cnt    = '0;
            led        = 1'b1;
            pwr        = 1'b1;
            errors     = 0;
            checked    = 0;
            arms       = 0;
            cancels    = 0;
            power_cycles = 0;
        endfunction

        // Mirror a register write, masked to the register width
        function void set_reg(logic [lppc_pkg::CFG_INDEX_W-1:0] idx,
                              logic [lppc_pkg::CFG_DATA_W-1:0] data);
            case (idx)
                lppc_pkg::CFG_HOLD_TICKS:   hold_lim   = data;
                lppc_pkg::CFG_CANCEL_TICKS: cancel_lim = data[7:0];
                lppc_pkg::CFG_OFF_TICKS:    off_lim    = data[7:0];
                lppc_pkg::CFG_BLINK_TICKS:  blink_lim  = data[7:0];
                lppc_pkg::CFG_DIM_PERIOD:   dim_per    = data[4:0];
                lppc_pkg::CFG_VOLTS:        volts_set  = data[4:0];
                default:                    ;
            endcase
        endfunction

        function logic [2:0] supply_code();
            logic [2:0] code;
            case (volts_set)
                5'd9:    code = lppc_pkg::VSEL_9V;
                5'd12:   code = lppc_pkg::VSEL_12V;
                5'd15:   code = lppc_pkg::VSEL_15V;
                5'd20:   code = lppc_pkg::VSEL_20V;
                default: code = lppc_pkg::VSEL_5V;
            endcase
            return code;
        endfunction

        // Advance the controller by one poll and queue the outputs it yields
        function void note_poll(logic held, logic tk);
            lppc_pkg::res_t r;
            logic restart;
            logic canceled;
            int   nxt;
            restart  = 1'b0;
            canceled = 1'b0;
            case (mode)
                lppc_pkg::MODE_RUN:
                begin
                    if (held)
                    begin
                        if (tk)
                        begin
                            hold_cnt = hold_cnt + 16'd1;
                            if (hold_cnt == hold_lim)
                            begin
                                mode       = lppc_pkg::MODE_ARMED;
                                cancel_cnt = '0;
                                dim_cnt    = '0;
                                arms++;
                            end
                        end
                    end
                    else
                    begin
                        restart  = 1'b1;
                        hold_cnt = '0;
                        led      = 1'b1;
                    end
                end
                lppc_pkg::MODE_ARMED:
                begin
                    if (held)
                    begin
                        if (tk)
                        begin
                            cancel_cnt = cancel_cnt + 8'd1;
                            if (cancel_cnt == cancel_lim)
                            begin
                                led      = 1'b1;
                                mode     = lppc_pkg::MODE_CANCELED;
                                canceled = 1'b1;
                                cancels++;
                            end
                        end
                        // Dim: lit on the first poll of each period only
                        if (!canceled)
                        begin
                            nxt = int'(dim_cnt) + 1;
                            led = (dim_cnt == 4'd0);
                            if (nxt >= int'(dim_per) || nxt >= 16)
                                nxt = 0;
                            dim_cnt = nxt[3:0];
                        end
                    end
                    else
                    begin
                        restart   = 1'b1;
                        pwr       = 1'b0;
                        off_cnt   = '0;
                        blink_cnt = '0;
                        mode      = lppc_pkg::MODE_OFF;
                        power_cycles++;
                    end
                end
                lppc_pkg::MODE_CANCELED:
                begin
                    if (!held)
                    begin
                        restart  = 1'b1;
                        hold_cnt = '0;
                        led      = 1'b1;
                        mode     = lppc_pkg::MODE_RUN;
                    end
                end
                default:
                begin
                    // Power off: count ticks, blink, ignore the button
                    if (off_cnt < off_lim && tk)
                    begin
                        off_cnt   = off_cnt + 8'd1;
                        blink_cnt = blink_cnt + 8'd1;
                        if (blink_cnt >= blink_lim)
                        begin
                            led       = ~led;
                            blink_cnt = '0;
                        end
                    end
                    if (off_cnt >= off_lim)
                    begin
                        pwr      = 1'b1;
                        led      = 1'b1;
                        hold_cnt = '0;
                        mode     = lppc_pkg::MODE_RUN;
                    end
                end
            endcase
            r.power_enable   = pwr;
            r.led_lit        = led;
            r.voltage_select = supply_code();
            r.timer_restart  = restart;
            pending_outputs.push_back(r);
        endfunction

        task report(string what);
            $display("MISMATCH at %0t: %s", $realtime, what);
            errors++;
        endtask

        // Compare one accepted result with the oldest expectation
        task check_result(logic pe, logic ll, logic [2:0] vs, logic tr);
            lppc_pkg::res_t want;
            if (pending_outputs.size() == 0)
            begin
                report("result transaction with no poll outstanding");
                return;
            end
            want = pending_outputs.pop_front();
            checked++;
            if (pe !== want.power_enable)
                report($sformatf("power_enable got %b want %b", pe, want.power_enable));
            if (ll !== want.led_lit)
                report($sformatf("led_lit got %b want %b", ll, want.led_lit));
            if (vs !== want.voltage_select)
                report($sformatf("voltage_select got %0d want %0d", vs,
                                 want.voltage_select));
            if (tr !== want.timer_restart)
                report($sformatf("timer_restart got %b want %b", tr, want.timer_restart));
        endtask

        function int pending_count();
            return pending_outputs.size();
        endfunction
    endclass

    logic                                 clk;
    logic                                 rst_n;
    logic                                 in_valid;
    logic                                 in_stall;
    logic                                 button_held;
    logic                                 tick;
    logic                                 out_valid;
    logic                                 out_stall = 1'b0;
    logic                                 power_enable;
    logic                                 led_lit;
    logic [2:0]                           voltage_select;
    logic                                 timer_restart;
    logic                                 cfg_valid;
    logic                                 cfg_ready;
    logic [lppc_pkg::CFG_INDEX_W-1:0]     cfg_index;
    logic [lppc_pkg::CFG_DATA_W-1:0]      cfg_data;

    power_cycle_scoreboard   sb;
    bit                      steady = 1'b0;
    int                      polls_sent = 0;
    int                      cfg_writes = 0;
    int                      phase_end = 0;

    // Directed opening polls, {button_held, tick}
    localparam logic [1:0] OPENING [23] = '{
        2'b00, 2'b01,                   // release in run
        2'b10, 2'b11, 2'b11,            // hold up to the arming tick
        2'b10, 2'b10, 2'b10, 2'b10,     // dimming while armed
        2'b00,                          // release while armed: power off
        2'b11, 2'b10, 2'b01, 2'b11,     // off with button ignored, then restore
        2'b11, 2'b11,                   // re-arm
        2'b11, 2'b11, 2'b11,            // hold on until canceled
        2'b11, 2'b10,                   // canceled, still held
        2'b00, 2'b01                    // release from canceled
    };

    long_press_power_cycle_controller_top u_dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .button_held    (button_held),
        .tick           (tick),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .power_enable   (power_enable),
        .led_lit        (led_lit),
        .voltage_select (voltage_select),
        .timer_restart  (timer_restart),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    // Stall the result channel at random outside the steady stretch
    always @(negedge clk)
    begin
        out_stall <= steady ? 1'b0 : ($urandom_range(0, 99) < 29);
    end

    // Check every accepted result transaction
    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
            sb.check_result(power_enable, led_lit, voltage_select, timer_restart);
    end

    // Hold off at random, then present one poll until it is taken
    task automatic send_poll(input logic h, input logic t);
        begin
            while (!steady && $urandom_range(0, 99) < 29)
            begin
                in_valid <= 1'b0;
                @(negedge clk);
            end
            in_valid    <= 1'b1;
            button_held <= h;
            tick        <= t;
            @(posedge clk);
            while (in_stall)
                @(posedge clk);
            sb.note_poll(h, t);
            polls_sent++;
            @(negedge clk);
        end
    endtask

    // Write one register; cfg_valid stays high for a following write
    task automatic write_reg(input logic [lppc_pkg::CFG_INDEX_W-1:0] idx,
                             input logic [lppc_pkg::CFG_DATA_W-1:0] data);
        begin
            cfg_valid <= 1'b1;
            cfg_index <= idx;
            cfg_data  <= data;
            @(posedge clk);
            while (!cfg_ready)
                @(posedge clk);
            sb.set_reg(idx, data);
            cfg_writes++;
            @(negedge clk);
        end
    endtask

    // Program all registers with junk in the unused upper bits
    task automatic setup_regs(input logic [15:0] h, input logic [7:0] c,
                              input logic [7:0] o, input logic [7:0] b,
                              input logic [4:0] d, input logic [4:0] v);
        logic [15:0] junk;
        begin
            junk = 16'($urandom);
            write_reg(lppc_pkg::CFG_HOLD_TICKS, h);
            write_reg(lppc_pkg::CFG_CANCEL_TICKS, {junk[15:8], c});
            junk = 16'($urandom);
            write_reg(lppc_pkg::CFG_OFF_TICKS, {junk[15:8], o});
            junk = 16'($urandom);
            write_reg(lppc_pkg::CFG_BLINK_TICKS, {junk[15:8], b});
            junk = 16'($urandom);
            write_reg(lppc_pkg::CFG_DIM_PERIOD, {junk[15:5], d});
            junk = 16'($urandom);
            write_reg(lppc_pkg::CFG_VOLTS, {junk[15:5], v});
            if ($urandom_range(0, 1))
                write_reg($urandom_range(0, 1) ? SPARE_INDEX_A : SPARE_INDEX_B,
                          16'($urandom));
            cfg_valid <= 1'b0;
        end
    endtask

    // Drop valid and wait for every outstanding result, then a short pause
    task automatic settle();
        int waited;
        begin
            waited = 0;
            in_valid <= 1'b0;
            while (sb.pending_count() != 0 && waited < 4000)
            begin
                @(negedge clk);
                waited++;
            end
            repeat (4) @(negedge clk);
        end
    endtask

    function automatic logic [4:0] pick_volts();
        int r;
        r = $urandom_range(0, 6);
        case (r)
            0:       return 5'd5;
            1:       return 5'd9;
            2:       return 5'd12;
            3:       return 5'd15;
            4:       return 5'd20;
            default: return 5'($urandom_range(0, 31));
        endcase
    endfunction

    // One press: random polls, or a hold for a chosen tick count (at most 300), release,
    // then ride out power-off; long holds and off periods are cut at the end of the phase budget
    task automatic press_sequence();
        int kind;
        int goal;
        int sent_ticks;
        int p;
        int cancel_eff;
        int off_eff;
        int ride;
        logic t;
        begin
            kind       = $urandom_range(0, 99);
            cancel_eff = (sb.cancel_lim == 8'd0) ? 256 : int'(sb.cancel_lim);
            off_eff    = int'(sb.off_lim);
            if (kind < 15)
            begin
                repeat ($urandom_range(1, 12))
                    send_poll(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
            end
            else
            begin
                p = $urandom_range(50, 100);
                if (kind < 35)
                    goal = int'(sb.hold_lim) - 1;
                else if (kind < 85)
                    goal = int'(sb.hold_lim) + $urandom_range(0, cancel_eff - 1);
                else
                    goal = int'(sb.hold_lim) + cancel_eff + $urandom_range(0, 2);
                if (goal > 300)
                    goal = 300;
                sent_ticks = 0;
                while (sent_ticks < goal && polls_sent < phase_end)
                begin
                    t = ($urandom_range(0, 99) < p);
                    send_poll(1'b1, t);
                    if (t)
                        sent_ticks++;
                end
                repeat ($urandom_range(0, 2))
                    send_poll(1'b1, 1'b0);
                repeat ($urandom_range(1, 3))
                    send_poll(1'b0, 1'($urandom_range(0, 1)));
                ride = off_eff + $urandom_range(0, 3);
                while (ride > 0 && polls_sent < phase_end)
                begin
                    send_poll(1'($urandom_range(0, 1)), $urandom_range(0, 9) < 8);
                    ride--;
                end
            end
        end
    endtask

    initial
    begin
        sb          = new();
        rst_n       = 1'b0;
        in_valid    = 1'b0;
        button_held = 1'b0;
        tick        = 1'b0;
        cfg_valid   = 1'b0;
        cfg_index   = '0;
        cfg_data    = '0;
        repeat (10) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Directed opening with short limits
        setup_regs(16'd2, 8'd3, 8'd3, 8'd1, 5'd3, 5'd9);
        foreach (OPENING[i])
            send_poll(OPENING[i][1], OPENING[i][0]);

        // Random phases, each under its own register setting
        for (int ph = 0; ph < 10; ph++)
        begin
            settle();
            case (ph)
                0: setup_regs(16'd1, 8'd1, 8'd1, 8'd1, 5'd1, 5'd0);
                1: setup_regs(16'd3, 8'd0, 8'd0, 8'd0, 5'd0, 5'd20);
                2: setup_regs(16'hFFFF, 8'd255, 8'd255, 8'd255, 5'd31, 5'd31);
                3: setup_regs(lppc_pkg::HOLD_TICKS_RST, lppc_pkg::CANCEL_TICKS_RST,
                              lppc_pkg::OFF_TICKS_RST, lppc_pkg::BLINK_TICKS_RST,
                              lppc_pkg::DIM_PERIOD_RST, lppc_pkg::VOLTS_RST);
                6: setup_regs(16'd2, 8'd255, 8'd255, 8'd200, 5'd16, 5'd15);
                default:
                    setup_regs(16'($urandom_range(1, 6)), 8'($urandom_range(0, 8)),
                               8'($urandom_range(0, 12)), 8'($urandom_range(0, 5)),
                               5'($urandom_range(0, 20)), pick_volts());
            endcase
            steady    = (ph == 5);
            phase_end = 23 + (ph + 1) * 108;
            while (polls_sent < phase_end)
                press_sequence();
            steady = 1'b0;
        end

        settle();
        if (sb.pending_count() != 0)
            sb.report($sformatf("%0d results never arrived", sb.pending_count()));
        $display("Covered %0d polls, %0d results checked, %0d register writes.",
                 polls_sent, sb.checked, cfg_writes);
        $display("Saw %0d arms, %0d cancels and %0d power cycles; %0d mismatches.",
                 sb.arms, sb.cancels, sb.power_cycles, sb.errors);
        if (sb.errors == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

    // Hard stop if the run hangs
    initial
    begin
        #4000000;
        $display("Run stopped after the time limit.");
        $display("RESULT: ERROR");
        $finish;
    end

endmodule

`default_nettype wire

[sim.f]
rtl/lppc_pkg.sv
rtl/lppc_cfg.sv
rtl/lppc_core.sv
rtl/long_press_power_cycle_controller_top.sv
sim/long_press_power_cycle_controller_top_tb.sv
